// File: src/urtrb_pkg.sv
// Package for the serial-port ring buffers: ring sizes, derived widths,
// event and status codes, and the transaction structs of both channels.
// No dependencies.
`default_nettype none

package urtrb_pkg;

  // Ring sizes (2 to 127 entries each)
  localparam int unsigned RX_DEPTH = 64;
  localparam int unsigned TX_DEPTH = 64;

  // Derived pointer and count widths
  localparam int unsigned RX_AW  = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW  = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW  = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_CW  = $clog2(TX_DEPTH + 1);

  // Fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FILL_W = 7;
  localparam int unsigned CODE_W = 3;

  // Event codes
  localparam logic [CODE_W-1:0] OP_HOST_WRITE = 3'd0;
  localparam logic [CODE_W-1:0] OP_TX_READY   = 3'd1;
  localparam logic [CODE_W-1:0] OP_RX_BYTE    = 3'd2;
  localparam logic [CODE_W-1:0] OP_HOST_READ  = 3'd3;
  localparam logic [CODE_W-1:0] OP_RX_FLUSH   = 3'd4;

  // Status codes
  localparam logic [CODE_W-1:0] ST_OK           = 3'd0;
  localparam logic [CODE_W-1:0] ST_DROP_FULL    = 3'd1;
  localparam logic [CODE_W-1:0] ST_DROP_FRAMING = 3'd2;
  localparam logic [CODE_W-1:0] ST_EMPTY_READ   = 3'd3;
  localparam logic [CODE_W-1:0] ST_IGNORED      = 3'd4;

  // Configuration register indexes
  localparam logic CFG_RX_NOTIFY = 1'b0;
  localparam logic CFG_TX_NOTIFY = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] operation;
    logic [BYTE_W-1:0] data_byte;
    logic              framing_error;
    logic              overrun_error;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_start;
    logic              tx_busy;
    logic              receive_enabled;
    logic [FILL_W-1:0] rx_fill;
    logic [FILL_W-1:0] tx_fill;
    logic              rx_notify;
    logic              tx_notify;
    logic [CODE_W-1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/urtrb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module urtrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/uart_rx_tx_ring_buffers.sv
// Top level of the serial-port ring buffers: event decode, ring pointers,
// result register. Uses urtrb_pkg and two urtrb_ram instances.
//
//  channel | signals                                  | transaction
//  --------+------------------------------------------+--------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i        | one event, on valid & ready
//  out     | out_valid_o, out_ready_i, out_data_o     | one result, on valid & ready
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i        | register write, on cfg_we_i
//
// An event that pops a ring (ready with bytes queued, read with bytes held)
// goes through S_READ, where the registered RAM byte is loaded into the result.
// Every other event loads its result directly. One event is in flight at a
// time; the next is taken when the result register is empty or drains in the same cycle.
// After reset both rings are empty and receive is enabled; no clearing pass.
`default_nettype none

module uart_rx_tx_ring_buffers (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire urtrb_pkg::in_item_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output urtrb_pkg::out_item_t     out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic                cfg_data_i
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q, out_valid_d;
  logic   rd_tx_q;
  urtrb_pkg::out_item_t res_q;

  logic [urtrb_pkg::RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [urtrb_pkg::RX_CW-1:0] rx_count_q, rx_count_d;
  logic [urtrb_pkg::TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [urtrb_pkg::TX_CW-1:0] tx_count_q, tx_count_d;
  logic tx_active_q, tx_active_d;
  logic rx_enabled_q, rx_enabled_d;
  logic rx_note_en_q, tx_note_en_q;

  logic in_fire;
  logic rx_we, rx_re, tx_we, tx_re;
  logic need_rd, rd_tx;
  logic [urtrb_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
  urtrb_pkg::out_item_t res;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // Result valid: set when a result is loaded, held until it drains
  assign out_valid_d = (state_q == S_READ) || (in_fire && !need_rd) ||
                       (out_valid_q && !out_ready_i);

  // Rings
  urtrb_ram #(
    .WIDTH (urtrb_pkg::BYTE_W),
    .DEPTH (urtrb_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_tail_q),
    .wdata_i (in_data_i.data_byte),
    .re_i    (rx_re),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  urtrb_ram #(
    .WIDTH (urtrb_pkg::BYTE_W),
    .DEPTH (urtrb_pkg::TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_tail_q),
    .wdata_i (in_data_i.data_byte),
    .re_i    (tx_re),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  // Event decode: pointer updates, RAM accesses, result fields
  always_comb begin
    rx_head_d    = rx_head_q;
    rx_tail_d    = rx_tail_q;
    rx_count_d   = rx_count_q;
    tx_head_d    = tx_head_q;
    tx_tail_d    = tx_tail_q;
    tx_count_d   = tx_count_q;
    tx_active_d  = tx_active_q;
    rx_enabled_d = rx_enabled_q;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    need_rd      = 1'b0;
    rd_tx        = 1'b0;
    res          = '0;
    res.status   = urtrb_pkg::ST_OK;

    if (in_fire) begin
      unique case (in_data_i.operation)
        urtrb_pkg::OP_HOST_WRITE: begin
          if (!tx_active_q) begin
            // idle transmitter takes the byte directly
            res.tx_byte  = in_data_i.data_byte;
            res.tx_start = 1'b1;
            tx_active_d  = 1'b1;
          end else if (tx_count_q == urtrb_pkg::TX_CW'(urtrb_pkg::TX_DEPTH)) begin
            res.status = urtrb_pkg::ST_DROP_FULL;
          end else begin
            tx_we      = 1'b1;
            tx_tail_d  = (tx_tail_q == urtrb_pkg::TX_AW'(urtrb_pkg::TX_DEPTH - 1))
                         ? '0 : tx_tail_q + 1'b1;
            tx_count_d = tx_count_q + 1'b1;
          end
        end
        urtrb_pkg::OP_TX_READY: begin
          if (!tx_active_q) begin
            res.status = urtrb_pkg::ST_IGNORED;
          end else if (tx_count_q == '0) begin
            tx_active_d = 1'b0;
          end else begin
            // byte arrives from RAM next cycle
            tx_re         = 1'b1;
            need_rd       = 1'b1;
            rd_tx         = 1'b1;
            tx_head_d     = (tx_head_q == urtrb_pkg::TX_AW'(urtrb_pkg::TX_DEPTH - 1))
                            ? '0 : tx_head_q + 1'b1;
            tx_count_d    = tx_count_q - 1'b1;
            res.tx_start  = 1'b1;
            res.tx_notify = tx_note_en_q;
          end
        end
        urtrb_pkg::OP_RX_BYTE: begin
          if (!rx_enabled_q) begin
            res.status = urtrb_pkg::ST_IGNORED;
          end else if (in_data_i.framing_error) begin
            res.status = urtrb_pkg::ST_DROP_FRAMING;
          end else begin
            if (in_data_i.overrun_error) begin
              rx_enabled_d = 1'b0;
            end
            if (rx_count_q == urtrb_pkg::RX_CW'(urtrb_pkg::RX_DEPTH)) begin
              res.status = urtrb_pkg::ST_DROP_FULL;
            end else begin
              rx_we         = 1'b1;
              rx_tail_d     = (rx_tail_q == urtrb_pkg::RX_AW'(urtrb_pkg::RX_DEPTH - 1))
                              ? '0 : rx_tail_q + 1'b1;
              rx_count_d    = rx_count_q + 1'b1;
              res.rx_notify = rx_note_en_q;
            end
          end
        end
        urtrb_pkg::OP_HOST_READ: begin
          if (rx_count_q == '0) begin
            res.status = urtrb_pkg::ST_EMPTY_READ;
          end else begin
            rx_re      = 1'b1;
            need_rd    = 1'b1;
            rx_head_d  = (rx_head_q == urtrb_pkg::RX_AW'(urtrb_pkg::RX_DEPTH - 1))
                         ? '0 : rx_head_q + 1'b1;
            rx_count_d = rx_count_q - 1'b1;
          end
        end
        urtrb_pkg::OP_RX_FLUSH: begin
          rx_head_d  = rx_tail_q;
          rx_count_d = '0;
        end
        default: begin
          res.status = urtrb_pkg::ST_IGNORED;
        end
      endcase
    end

    // state after the event
    res.tx_busy         = tx_active_d;
    res.receive_enabled = rx_enabled_d;
    res.rx_fill         = urtrb_pkg::FILL_W'(rx_count_d);
    res.tx_fill         = urtrb_pkg::FILL_W'(tx_count_d);
  end

  // Sequencer, ring state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      rd_tx_q      <= 1'b0;
      res_q        <= '0;
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      rx_count_q   <= '0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      tx_count_q   <= '0;
      tx_active_q  <= 1'b0;
      rx_enabled_q <= 1'b1;
      rx_note_en_q <= 1'b0;
      tx_note_en_q <= 1'b0;
    end else begin
      rx_head_q    <= rx_head_d;
      rx_tail_q    <= rx_tail_d;
      rx_count_q   <= rx_count_d;
      tx_head_q    <= tx_head_d;
      tx_tail_q    <= tx_tail_d;
      tx_count_q   <= tx_count_d;
      tx_active_q  <= tx_active_d;
      rx_enabled_q <= rx_enabled_d;
      out_valid_q  <= out_valid_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          urtrb_pkg::CFG_RX_NOTIFY: rx_note_en_q <= cfg_data_i;
          urtrb_pkg::CFG_TX_NOTIFY: tx_note_en_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_q <= res;
            if (need_rd) begin
              state_q <= S_READ;
              rd_tx_q <= rd_tx;
            end
          end
        end
        S_READ: begin
          // RAM data is valid now
          if (rd_tx_q) begin
            res_q.tx_byte <= tx_rdata;
          end else begin
            res_q.read_data <= rx_rdata;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/urtrb_ring_checker.sv
// Result checker for the serial-port ring buffers: watches the event, result and
// register-write channels, keeps its own copy of both rings, and compares every
// result field by field. Depends on urtrb_pkg.
module urtrb_ring_checker
  import urtrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the rings and flags
  logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
  logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
  logic [RX_AW-1:0]  rx_rd, rx_wr;
  logic [TX_AW-1:0]  tx_rd, tx_wr;
  logic [RX_CW-1:0]  rx_level;
  logic [TX_CW-1:0]  tx_level;
  logic              tx_sending;
  logic              rx_open;
  logic              rx_note_en, tx_note_en;

  out_item_t   due_results [$];
  int unsigned backlog     = 0;
  int unsigned checked     = 0;
  int unsigned mismatches  = 0;

  logic in_fire, out_fire;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_fire  = out_valid_i && out_ready_i;
  assign pending_o = backlog;
  assign checked_o = checked;
  assign errors_o  = mismatches;

  function automatic int unsigned wrap_inc(input int unsigned ptr, input int unsigned depth);
    return (ptr + 1 >= depth) ? 0 : ptr + 1;
  endfunction

  // Apply one event to the shadow rings and return the result it should produce
  function automatic out_item_t next_ring_result(input in_item_t ev);
    out_item_t r;
    r = '0;
    r.status = ST_OK;
    case (ev.operation)
      OP_HOST_WRITE: begin
        if (!tx_sending) begin
          // idle transmitter: byte goes straight out
          r.tx_byte  = ev.data_byte;
          r.tx_start = 1'b1;
          tx_sending = 1'b1;
        end else if (tx_level >= TX_DEPTH) begin
          r.status = ST_DROP_FULL;
        end else begin
          tx_ring[tx_wr] = ev.data_byte;
          tx_wr          = TX_AW'(wrap_inc(tx_wr, TX_DEPTH));
          tx_level       = tx_level + 1'b1;
        end
      end
      OP_TX_READY: begin
        if (!tx_sending) begin
          r.status = ST_IGNORED;
        end else if (tx_level == 0) begin
          tx_sending = 1'b0;
        end else begin
          r.tx_byte   = tx_ring[tx_rd];
          r.tx_start  = 1'b1;
          r.tx_notify = tx_note_en;
          tx_rd       = TX_AW'(wrap_inc(tx_rd, TX_DEPTH));
          tx_level    = tx_level - 1'b1;
        end
      end
      OP_RX_BYTE: begin
        if (!rx_open) begin
          r.status = ST_IGNORED;
        end else if (ev.framing_error) begin
          // overrun flag is not looked at on a framing error
          r.status = ST_DROP_FRAMING;
        end else begin
          if (ev.overrun_error) rx_open = 1'b0;
          if (rx_level >= RX_DEPTH) begin
            r.status = ST_DROP_FULL;
          end else begin
            rx_ring[rx_wr] = ev.data_byte;
            rx_wr          = RX_AW'(wrap_inc(rx_wr, RX_DEPTH));
            rx_level       = rx_level + 1'b1;
            r.rx_notify    = rx_note_en;
          end
        end
      end
      OP_HOST_READ: begin
        if (rx_level == 0) begin
          r.status = ST_EMPTY_READ;
        end else begin
          r.read_data = rx_ring[rx_rd];
          rx_rd       = RX_AW'(wrap_inc(rx_rd, RX_DEPTH));
          rx_level    = rx_level - 1'b1;
        end
      end
      OP_RX_FLUSH: begin
        rx_rd    = rx_wr;
        rx_level = '0;
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    r.tx_busy         = tx_sending;
    r.receive_enabled = rx_open;
    r.rx_fill         = FILL_W'(rx_level);
    r.tx_fill         = FILL_W'(tx_level);
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("t=%0t %s: expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  // Track events in, results out and register writes
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      rx_rd      = '0;
      rx_wr      = '0;
      rx_level   = '0;
      tx_rd      = '0;
      tx_wr      = '0;
      tx_level   = '0;
      tx_sending = 1'b0;
      rx_open    = 1'b1;
      rx_note_en = 1'b0;
      tx_note_en = 1'b0;
      due_results.delete();
      backlog <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_RX_NOTIFY) rx_note_en = cfg_data_i;
        else tx_note_en = cfg_data_i;
      end
      if (out_fire) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("t=%0t result with no event pending: expected none, got %h",
                   $time, out_data_i);
        end else begin
          want = due_results.pop_front();
          checked++;
          compare_field("read_data", want.read_data, out_data_i.read_data);
          compare_field("tx_byte", want.tx_byte, out_data_i.tx_byte);
          compare_field("tx_start", want.tx_start, out_data_i.tx_start);
          compare_field("tx_busy", want.tx_busy, out_data_i.tx_busy);
          compare_field("receive_enabled", want.receive_enabled,
                        out_data_i.receive_enabled);
          compare_field("rx_fill", want.rx_fill, out_data_i.rx_fill);
          compare_field("tx_fill", want.tx_fill, out_data_i.tx_fill);
          compare_field("rx_notify", want.rx_notify, out_data_i.rx_notify);
          compare_field("tx_notify", want.tx_notify, out_data_i.tx_notify);
          compare_field("status", want.status, out_data_i.status);
        end
      end
      if (in_fire) due_results.push_back(next_ring_result(in_data_i));
      backlog <= due_results.size();
    end
  end

endmodule

// File: verif/tb_uart_rx_tx_ring_buffers.sv
// Top of the ring-buffer testbench: clock, reset, event and stall generation,
// notify register settings and the verdict. Depends on urtrb_pkg, the block
// and urtrb_ring_checker.
module tb_uart_rx_tx_ring_buffers;
  timeunit 1ns;
  timeprecision 1ps;
  import urtrb_pkg::*;

  // Codes 5 to 7 have no meaning and must be ignored
  localparam logic [CODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [CODE_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int unsigned RANDOM_EVENTS = 760;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned TIMEOUT_NS    = 4_000_000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_RX_NOTIFY;
  logic        cfg_data  = 1'b0;

  int unsigned pending, checked, errors;
  int unsigned events_sent = 0;
  int unsigned op_seen [8];
  int unsigned gap_odds    = 2;
  logic        calm        = 1'b0;

  uart_rx_tx_ring_buffers dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  urtrb_ring_checker ring_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .checked_o   (checked),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still due", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall bursts, none once the run turns calm
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // One event transaction, with an optional gap before it
  task automatic send_event(input logic [CODE_W-1:0] op, input logic [BYTE_W-1:0] data,
                            input logic ferr, input logic oerr);
    in_item_t ev;
    ev.operation     = op;
    ev.data_byte     = data;
    ev.framing_error = ferr;
    ev.overrun_error = oerr;
    if (!calm && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    events_sent++;
    op_seen[op]++;
  endtask

  // Stop sending and wait until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_notify(input logic rx_en, input logic tx_en);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RX_NOTIFY;
    cfg_data  <= rx_en;
    @(posedge clk);
    cfg_index <= CFG_TX_NOTIFY;
    cfg_data  <= tx_en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Host writes, then some ready events; sometimes enough writes to overflow
  task automatic tx_burst();
    int unsigned n;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(TX_DEPTH, TX_DEPTH + 4)
                                     : $urandom_range(1, 8);
    repeat (n) send_event(OP_HOST_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, n + 2))
      send_event(OP_TX_READY, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Received bytes (no overrun), then reads and the odd flush
  task automatic rx_burst();
    int unsigned n;
    logic        fe, oe;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(RX_DEPTH, RX_DEPTH + 4)
                                     : $urandom_range(1, 8);
    repeat (n) begin
      fe = ($urandom_range(0, 9) == 0);
      oe = fe & 1'($urandom);
      send_event(OP_RX_BYTE, 8'($urandom), fe, oe);
    end
    if ($urandom_range(0, 7) == 0)
      send_event(OP_RX_FLUSH, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, n + 2))
      send_event(OP_HOST_READ, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Any code, any fields, but never an overrun that would close receive
  task automatic noise_burst();
    logic [CODE_W-1:0] op;
    logic              fe, oe;
    repeat ($urandom_range(1, 6)) begin
      op = CODE_W'($urandom);
      fe = 1'($urandom);
      oe = (op == OP_RX_BYTE && !fe) ? 1'b0 : 1'($urandom);
      send_event(op, 8'($urandom), fe, oe);
    end
  endtask

  // Stimulus
  initial begin
    int unsigned phase_start, r;
    logic [1:0]  notify_sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_notify(1'b1, 1'b1);

    // Directed: transmit path
    send_event(OP_TX_READY, 8'hFF, 1'b1, 1'b1);    // ready while idle
    send_event(OP_HOST_READ, 8'hFF, 1'b1, 1'b1);   // read of empty ring
    send_event(OP_HOST_WRITE, 8'h00, 1'b0, 1'b0);  // straight to transmitter
    send_event(OP_HOST_WRITE, 8'hFF, 1'b1, 1'b1);
    send_event(OP_HOST_WRITE, 8'h80, 1'b0, 1'b0);
    send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
    send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
    send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);    // empty ring ends transmit
    send_event(OP_TX_READY, 8'h00, 1'b0, 1'b0);
    // Directed: receive path
    send_event(OP_RX_BYTE, 8'h00, 1'b0, 1'b0);
    send_event(OP_RX_BYTE, 8'hFF, 1'b0, 1'b0);
    send_event(OP_RX_BYTE, 8'h3C, 1'b1, 1'b1);     // framing wins over overrun
    send_event(OP_RX_BYTE, 8'h01, 1'b1, 1'b0);
    send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
    send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
    send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
    send_event(OP_RX_BYTE, 8'h7F, 1'b0, 1'b0);
    send_event(OP_RX_FLUSH, 8'hFF, 1'b1, 1'b1);    // flush with a byte held
    send_event(OP_HOST_READ, 8'h00, 1'b0, 1'b0);
    send_event(OP_RX_FLUSH, 8'h00, 1'b0, 1'b0);    // flush of empty ring
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_event(CODE_W'(op), 8'hFF, 1'b1, 1'b1);

    // Random: four notify settings, quiet toward the end
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      notify_sel = 2'(phase);
      set_notify(notify_sel[0] ~^ notify_sel[1], ~notify_sel[1]);
      phase_start = events_sent;
      while (events_sent - phase_start < RANDOM_EVENTS / 4) begin
        calm     = (phase == 3) && (events_sent - phase_start >= RANDOM_EVENTS / 8);
        gap_odds = $urandom_range(0, 3);
        r        = $urandom_range(0, 9);
        if (r < 4) tx_burst();
        else if (r < 8) rx_burst();
        else noise_burst();
      end
    end

    // Closing: both rings full, then the one overrun the run allows
    calm = 1'b1;
    repeat (TX_DEPTH + 2) send_event(OP_HOST_WRITE, 8'($urandom), 1'b0, 1'b0);
    repeat (TX_DEPTH + 2) send_event(OP_TX_READY, 8'($urandom), 1'b0, 1'b0);
    send_event(OP_RX_FLUSH, 8'($urandom), 1'b0, 1'b0);
    repeat (RX_DEPTH + 1) send_event(OP_RX_BYTE, 8'($urandom), 1'b0, 1'b0);
    // with room the overrun byte is stored, without it is dropped
    if ($urandom_range(0, 1) == 1) send_event(OP_HOST_READ, 8'($urandom), 1'b0, 1'b0);
    send_event(OP_RX_BYTE, 8'($urandom), 1'b0, 1'b1);
    send_event(OP_RX_BYTE, 8'($urandom), 1'b0, 1'b0);  // receive now closed
    send_event(OP_RX_BYTE, 8'($urandom), 1'b1, 1'b1);
    repeat (3) send_event(OP_HOST_READ, 8'($urandom), 1'b0, 1'b0);
    send_event(OP_RX_FLUSH, 8'($urandom), 1'b0, 1'b0);
    send_event(OP_HOST_READ, 8'($urandom), 1'b0, 1'b0);
    wait_idle();

    $display({"Covered %0d events: %0d writes, %0d ready, %0d receive, ",
              "%0d reads, %0d flushes, %0d spare codes"},
             events_sent, op_seen[OP_HOST_WRITE], op_seen[OP_TX_READY],
             op_seen[OP_RX_BYTE], op_seen[OP_HOST_READ], op_seen[OP_RX_FLUSH],
             op_seen[5] + op_seen[6] + op_seen[7]);
    $display({"%0d results checked over four notify settings, ",
              "ending with full rings and an overrun"},
             checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
src/urtrb_pkg.sv
src/urtrb_ram.sv
src/uart_rx_tx_ring_buffers.sv
verif/urtrb_ring_checker.sv
verif/tb_uart_rx_tx_ring_buffers.sv
